// File: sv/hta_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hta_pkg
// Shared constants, beat layout and the sequencer program of the handle
// table allocator.
// ----------------------------------------------------------------------------
package hta_pkg;

    localparam int SLOTS_DEF       = 256;
    localparam int OBJECT_BITS_DEF = 16;

    // Beat layout, lowest bit first
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;
    localparam int OPC_W    = 2;
    localparam int OBJ_W    = 16;
    localparam int HDL_W    = 8;
    localparam int REF_W    = 2;

    localparam logic [OPC_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OPC_W-1:0] OP_LOOKUP   = 2'd1;
    localparam logic [OPC_W-1:0] OP_RELEASE  = 2'd2;
    localparam logic [OPC_W-1:0] OP_NOP      = 2'd3;

    localparam logic [REF_W-1:0] REF_NONE = 2'd0;
    localparam logic [REF_W-1:0] REF_INC  = 2'd1;
    localparam logic [REF_W-1:0] REF_DEC  = 2'd2;

    // Program steps
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] PC_IDLE    = 3'd0;
    localparam logic [PC_W-1:0] PC_CHECK   = 3'd1;
    localparam logic [PC_W-1:0] PC_ADVANCE = 3'd2;
    localparam logic [PC_W-1:0] PC_SCAN    = 3'd3;
    localparam logic [PC_W-1:0] PC_REG_FIN = 3'd4;
    localparam logic [PC_W-1:0] PC_HDL_FIN = 3'd5;
    localparam logic [PC_W-1:0] PC_EMIT    = 3'd6;
    localparam logic [PC_W-1:0] PC_CLEAR   = 3'd7;

    typedef enum logic [2:0] {
        A_NONE    = 3'd0,
        A_ACCEPT  = 3'd1,
        A_ADVANCE = 3'd2,
        A_SCAN    = 3'd3,
        A_REG_FIN = 3'd4,
        A_HDL_FIN = 3'd5,
        A_EMIT    = 3'd6,
        A_CLEAR   = 3'd7
    } act_t;

    typedef enum logic [2:0] {
        C_ALWAYS    = 3'd0,
        C_ACCEPT    = 3'd1,
        C_SKIP      = 3'd2,
        C_HANDLE_OP = 3'd3,
        C_SCAN_DONE = 3'd4,
        C_OUT_FREE  = 3'd5,
        C_CLR_DONE  = 3'd6
    } cond_t;

    // When cond holds the step counter loads target; otherwise it steps on
    // if adv is set and stays put if not.
    typedef struct packed {
        act_t            act;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            adv;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            PC_IDLE:    w = '{A_ACCEPT,  C_ACCEPT,    PC_CHECK,   1'b0};
            PC_CHECK:   w = '{A_NONE,    C_SKIP,      PC_EMIT,    1'b1};
            PC_ADVANCE: w = '{A_ADVANCE, C_HANDLE_OP, PC_HDL_FIN, 1'b1};
            PC_SCAN:    w = '{A_SCAN,    C_SCAN_DONE, PC_REG_FIN, 1'b0};
            PC_REG_FIN: w = '{A_REG_FIN, C_ALWAYS,    PC_EMIT,    1'b0};
            PC_HDL_FIN: w = '{A_HDL_FIN, C_ALWAYS,    PC_EMIT,    1'b0};
            PC_EMIT:    w = '{A_EMIT,    C_OUT_FREE,  PC_IDLE,    1'b0};
            PC_CLEAR:   w = '{A_CLEAR,   C_CLR_DONE,  PC_IDLE,    1'b0};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: sv/hta_slot_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hta_slot_ram
// Slot store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hta_slot_ram #(
    parameter int DEPTH = hta_pkg::SLOTS_DEF,
    parameter int AW    = $clog2(hta_pkg::SLOTS_DEF),
    parameter int DW    = hta_pkg::OBJECT_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: sv/handle_table_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// handle_table_allocator
// Next-fit handle table: maps handles 1..SLOTS-1 to object ids, run by a
// small microcoded sequencer over a single slot RAM.
// ----------------------------------------------------------------------------
//  Channel  Dir  Width  Contents (lowest bit first)
//  s_       in   32     opcode[1:0], object_id[17:2], handle_in[25:18]
//  m_       out  32     handle_out[7:0], object_out[23:8], hit[24],
//                       ref_change[26:25]
//
// A register item reads every slot once through the RAM's single read port,
// looking for the same object and for the first free slot from the next-fit
// pointer at once. After reset a clearing pass zeroes the RAM; no beat is
// accepted meanwhile. A stalled result beat is held in the output register
// while the next input beat is accepted and worked on.
// ----------------------------------------------------------------------------
module handle_table_allocator #(
    parameter int SLOTS       = hta_pkg::SLOTS_DEF,
    parameter int OBJECT_BITS = hta_pkg::OBJECT_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [hta_pkg::S_DATA_W-1:0]  s_tdata,  // opcode, object_id, handle_in
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [hta_pkg::M_DATA_W-1:0]  m_tdata   // handle_out, object_out, hit, ref_change
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int HW    = (IDX_W > hta_pkg::HDL_W) ? IDX_W : hta_pkg::HDL_W;
    localparam int XW    = (OBJECT_BITS > hta_pkg::OBJ_W) ? OBJECT_BITS : hta_pkg::OBJ_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W-1:0] FIRST = IDX_W'(1);

    // Input beat fields
    logic [hta_pkg::OPC_W-1:0] in_opcode;
    logic [hta_pkg::OBJ_W-1:0] in_object;
    logic [hta_pkg::HDL_W-1:0] in_handle;
    logic [HW-1:0]             in_handle_ext;
    logic [XW-1:0]             in_object_ext;
    logic                      in_range;

    assign in_opcode     = s_tdata[1:0];
    assign in_object     = s_tdata[17:2];
    assign in_handle     = s_tdata[25:18];
    assign in_handle_ext = HW'(in_handle);
    assign in_object_ext = XW'(in_object);
    assign in_range      = (in_handle != '0) && (32'(in_handle) < 32'(SLOTS));

    // Sequencer and datapath registers
    logic [hta_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic [hta_pkg::OPC_W-1:0] op_reg, op_next;
    logic [OBJECT_BITS-1:0]    obj_reg, obj_next;
    logic                      range_reg, range_next;
    logic [IDX_W-1:0]          hidx_reg, hidx_next;
    logic [IDX_W-1:0]          addr_reg, addr_next;
    logic [IDX_W-1:0]          cmp_reg, cmp_next;
    logic                      dup_reg, dup_next;
    logic [IDX_W-1:0]          dup_idx_reg, dup_idx_next;
    logic                      lo_reg, lo_next;
    logic [IDX_W-1:0]          lo_idx_reg, lo_idx_next;
    logic                      hi_reg, hi_next;
    logic [IDX_W-1:0]          hi_idx_reg, hi_idx_next;
    logic [IDX_W-1:0]          next_slot_reg, next_slot_next;
    logic [hta_pkg::HDL_W-1:0] res_handle_reg, res_handle_next;
    logic [hta_pkg::OBJ_W-1:0] res_object_reg, res_object_next;
    logic                      res_hit_reg, res_hit_next;
    logic [hta_pkg::REF_W-1:0] res_ref_reg, res_ref_next;
    logic                      m_valid_reg, m_valid_next;
    logic [hta_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    // RAM port signals
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [OBJECT_BITS-1:0] ram_wdata;
    logic [OBJECT_BITS-1:0] ram_q;

    hta_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (IDX_W),
        .DW    (OBJECT_BITS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_q)
    );

    hta_pkg::ucode_t uc;
    logic            accept;
    logic            out_free;
    logic            take;
    logic [IDX_W-1:0] addr_inc;
    logic [IDX_W-1:0] free_slot;
    logic [IDX_W-1:0] reg_slot;
    logic [HW-1:0]    reg_slot_ext;
    logic [XW-1:0]    q_ext;
    logic [XW-1:0]    obj_ext;

    assign uc           = hta_pkg::ucode_rom(pc_reg);
    assign s_tready     = (pc_reg == hta_pkg::PC_IDLE);
    assign accept       = s_tvalid && s_tready;
    assign out_free     = !m_valid_reg || m_tready;
    assign addr_inc     = (addr_reg == LAST) ? '0 : addr_reg + FIRST;
    assign free_slot    = hi_reg ? hi_idx_reg : lo_idx_reg;
    assign reg_slot     = dup_reg ? dup_idx_reg : free_slot;
    assign reg_slot_ext = HW'(reg_slot);
    assign q_ext        = XW'(ram_q);
    assign obj_ext      = XW'(obj_reg);

    // Jump condition of the current control word
    always_comb begin
        unique case (uc.cond)
            hta_pkg::C_ALWAYS:    take = 1'b1;
            hta_pkg::C_ACCEPT:    take = accept;
            hta_pkg::C_SKIP:      take = (op_reg == hta_pkg::OP_NOP) ||
                                         ((op_reg == hta_pkg::OP_REGISTER) && (obj_reg == '0));
            hta_pkg::C_HANDLE_OP: take = (op_reg == hta_pkg::OP_LOOKUP) ||
                                         (op_reg == hta_pkg::OP_RELEASE);
            hta_pkg::C_SCAN_DONE: take = (cmp_reg == LAST);
            hta_pkg::C_OUT_FREE:  take = out_free;
            hta_pkg::C_CLR_DONE:  take = (addr_reg == LAST);
            default:              take = 1'b0;
        endcase
        if (take) begin
            pc_next = uc.target;
        end else if (uc.adv) begin
            pc_next = pc_reg + hta_pkg::PC_W'(1);
        end else begin
            pc_next = pc_reg;
        end
    end

    // Datapath driven by the action field
    always_comb begin
        op_next         = op_reg;
        obj_next        = obj_reg;
        range_next      = range_reg;
        hidx_next       = hidx_reg;
        addr_next       = addr_reg;
        cmp_next        = cmp_reg;
        dup_next        = dup_reg;
        dup_idx_next    = dup_idx_reg;
        lo_next         = lo_reg;
        lo_idx_next     = lo_idx_reg;
        hi_next         = hi_reg;
        hi_idx_next     = hi_idx_reg;
        next_slot_next  = next_slot_reg;
        res_handle_next = res_handle_reg;
        res_object_next = res_object_reg;
        res_hit_next    = res_hit_reg;
        res_ref_next    = res_ref_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = '0;

        unique case (uc.act)
            hta_pkg::A_NONE: begin
            end
            hta_pkg::A_ACCEPT: begin
                if (accept) begin
                    op_next         = in_opcode;
                    obj_next        = in_object_ext[OBJECT_BITS-1:0];
                    range_next      = in_range;
                    hidx_next       = in_range ? in_handle_ext[IDX_W-1:0] : '0;
                    // Lookup and release read their slot; register scans from 1.
                    addr_next       = (in_opcode == hta_pkg::OP_REGISTER) ? FIRST :
                                      (in_range ? in_handle_ext[IDX_W-1:0] : '0);
                    dup_next        = 1'b0;
                    lo_next         = 1'b0;
                    hi_next         = 1'b0;
                    res_handle_next = '0;
                    res_object_next = '0;
                    res_hit_next    = 1'b0;
                    res_ref_next    = hta_pkg::REF_NONE;
                end
            end
            hta_pkg::A_ADVANCE: begin
                cmp_next  = addr_reg;
                addr_next = addr_inc;
            end
            hta_pkg::A_SCAN: begin
                // The read data belongs to the slot one step behind the address.
                cmp_next  = addr_reg;
                addr_next = addr_inc;
                if (!dup_reg && (ram_q == obj_reg)) begin
                    dup_next     = 1'b1;
                    dup_idx_next = cmp_reg;
                end
                if (ram_q == '0) begin
                    if (!lo_reg) begin
                        lo_next     = 1'b1;
                        lo_idx_next = cmp_reg;
                    end
                    if (!hi_reg && (cmp_reg >= next_slot_reg)) begin
                        hi_next     = 1'b1;
                        hi_idx_next = cmp_reg;
                    end
                end
            end
            hta_pkg::A_REG_FIN: begin
                if (dup_reg || lo_reg) begin
                    res_handle_next = reg_slot_ext[hta_pkg::HDL_W-1:0];
                    res_object_next = obj_ext[hta_pkg::OBJ_W-1:0];
                    res_hit_next    = 1'b1;
                end
                if (!dup_reg && lo_reg) begin
                    ram_we         = 1'b1;
                    ram_waddr      = free_slot;
                    ram_wdata      = obj_reg;
                    res_ref_next   = hta_pkg::REF_INC;
                    next_slot_next = (free_slot == LAST) ? FIRST : free_slot + FIRST;
                end
            end
            hta_pkg::A_HDL_FIN: begin
                if (range_reg && (ram_q != '0)) begin
                    res_object_next = q_ext[hta_pkg::OBJ_W-1:0];
                    res_hit_next    = 1'b1;
                    if (op_reg == hta_pkg::OP_RELEASE) begin
                        ram_we       = 1'b1;
                        ram_waddr    = hidx_reg;
                        res_ref_next = hta_pkg::REF_DEC;
                    end
                end
            end
            hta_pkg::A_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'b0, res_ref_reg, res_hit_reg,
                                    res_object_reg, res_handle_reg};
                end
            end
            hta_pkg::A_CLEAR: begin
                ram_we    = 1'b1;
                addr_next = addr_inc;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= hta_pkg::PC_CLEAR;
            addr_reg      <= '0;
            next_slot_reg <= FIRST;
            m_valid_reg   <= 1'b0;
        end else begin
            pc_reg        <= pc_next;
            addr_reg      <= addr_next;
            next_slot_reg <= next_slot_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        obj_reg        <= obj_next;
        range_reg      <= range_next;
        hidx_reg       <= hidx_next;
        cmp_reg        <= cmp_next;
        dup_reg        <= dup_next;
        dup_idx_reg    <= dup_idx_next;
        lo_reg         <= lo_next;
        lo_idx_reg     <= lo_idx_next;
        hi_reg         <= hi_next;
        hi_idx_reg     <= hi_idx_next;
        res_handle_reg <= res_handle_next;
        res_object_reg <= res_object_next;
        res_hit_reg    <= res_hit_next;
        res_ref_reg    <= res_ref_next;
        m_data_reg     <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the handle table allocator. A shadow handle table
// inside a small scoreboard class works out the answer to every command beat
// taken by the block. Each result beat is then compared field by field with
// the oldest outstanding answer. Stimulus opens with a handful of corner
// cases. Random blocks follow: they mix registration, lookup and release,
// and two flooding blocks drive the table full and past it. Both sides idle
// at random, except in some blocks where they run flat out.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [hta_pkg::REF_W-1:0] refc;
    logic                      hit;
    logic [hta_pkg::OBJ_W-1:0] obj;
    logic [hta_pkg::HDL_W-1:0] hdl;
} alloc_result_t;

class handle_scoreboard;
    logic [hta_pkg::OBJ_W-1:0] slot_obj [hta_pkg::SLOTS_DEF];
    int                        next_fit;
    alloc_result_t             expected_q [$];
    int                        errors;

    function new();
        foreach (slot_obj[i]) slot_obj[i] = '0;
        next_fit = 1;
        errors   = 0;
    endfunction

    // Carries one command out on the shadow table and returns its answer.
    function alloc_result_t apply_cmd(logic [hta_pkg::OPC_W-1:0] op,
                                      logic [hta_pkg::OBJ_W-1:0] obj,
                                      logic [hta_pkg::HDL_W-1:0] hdl);
        alloc_result_t res;
        int            start;
        int            h;
        int            k;
        bit            done;
        res  = '0;
        done = 1'b0;
        unique case (op)
            hta_pkg::OP_REGISTER: begin
                if (obj != '0) begin
                    // An object already held keeps its handle and its references.
                    for (k = 1; k < hta_pkg::SLOTS_DEF; k++) begin
                        if (!done && slot_obj[k] == obj) begin
                            res.hdl = k[hta_pkg::HDL_W-1:0];
                            res.obj = obj;
                            res.hit = 1'b1;
                            done    = 1'b1;
                        end
                    end
                    if (!done) begin
                        start = (next_fit == 0 || next_fit >= hta_pkg::SLOTS_DEF) ?
                                1 : next_fit;
                        for (k = 0; k < hta_pkg::SLOTS_DEF - 1; k++) begin
                            h = start + k;
                            if (h >= hta_pkg::SLOTS_DEF) h = h - (hta_pkg::SLOTS_DEF - 1);
                            if (!done && slot_obj[h] == '0) begin
                                slot_obj[h] = obj;
                                next_fit    = (h + 1 >= hta_pkg::SLOTS_DEF) ? 1 : h + 1;
                                res.hdl     = h[hta_pkg::HDL_W-1:0];
                                res.obj     = obj;
                                res.hit     = 1'b1;
                                res.refc    = hta_pkg::REF_INC;
                                done        = 1'b1;
                            end
                        end
                    end
                end
            end
            hta_pkg::OP_LOOKUP: begin
                if (hdl != '0 && slot_obj[hdl] != '0) begin
                    res.obj = slot_obj[hdl];
                    res.hit = 1'b1;
                end
            end
            hta_pkg::OP_RELEASE: begin
                if (hdl != '0 && slot_obj[hdl] != '0) begin
                    res.obj       = slot_obj[hdl];
                    res.hit       = 1'b1;
                    res.refc      = hta_pkg::REF_DEC;
                    slot_obj[hdl] = '0;
                end
            end
            default: res = '0;
        endcase
        return res;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    task report(string msg);
        if (errors < 40) $display("%0t: %s", $time, msg);
        errors++;
    endtask

    task note_input(logic [hta_pkg::S_DATA_W-1:0] beat);
        expected_q.push_back(apply_cmd(beat[1:0], beat[17:2], beat[25:18]));
    endtask

    task check_result(logic [hta_pkg::M_DATA_W-1:0] beat);
        alloc_result_t want;
        if (expected_q.size() == 0) begin
            report($sformatf("result beat %h arrived with no command outstanding", beat));
            return;
        end
        want = expected_q.pop_front();
        if (beat[7:0] !== want.hdl)
            report($sformatf("handle_out %h, expected %h", beat[7:0], want.hdl));
        if (beat[23:8] !== want.obj)
            report($sformatf("object_out %h, expected %h", beat[23:8], want.obj));
        if (beat[24] !== want.hit)
            report($sformatf("hit %b, expected %b", beat[24], want.hit));
        if (beat[26:25] !== want.refc)
            report($sformatf("ref_change %0d, expected %0d", beat[26:25], want.refc));
        if (beat[31:27] !== '0)
            report($sformatf("padding bits %b are not zero", beat[31:27]));
    endtask
endclass

module testbench;

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [hta_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [hta_pkg::M_DATA_W-1:0] m_tdata;

    bit                           no_idle  = 1'b0;
    handle_scoreboard             sb;

    handle_table_allocator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_cmd(input logic [hta_pkg::OPC_W-1:0] op,
                            input logic [hta_pkg::OBJ_W-1:0] obj,
                            input logic [hta_pkg::HDL_W-1:0] hdl);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(hta_pkg::S_DATA_W - hta_pkg::OPC_W - hta_pkg::OBJ_W -
                       hta_pkg::HDL_W){1'b0}}, hdl, obj, op};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Picks an occupied handle where there is one, so lookups and releases mostly land.
    function automatic logic [hta_pkg::HDL_W-1:0] live_handle();
        int h;
        int k;
        h = $urandom_range(1, hta_pkg::SLOTS_DEF - 1);
        for (k = 0; k < hta_pkg::SLOTS_DEF - 1; k++) begin
            if (sb.slot_obj[h] != '0) return h[hta_pkg::HDL_W-1:0];
            h = (h == hta_pkg::SLOTS_DEF - 1) ? 1 : h + 1;
        end
        return h[hta_pkg::HDL_W-1:0];
    endfunction

    task automatic random_cmd(input int reg_pct, input int dup_pct);
        int                        roll;
        logic [31:0]               rnd;
        logic [hta_pkg::OBJ_W-1:0] obj;
        logic [hta_pkg::OBJ_W-1:0] held;
        logic [hta_pkg::HDL_W-1:0] hdl;
        roll = $urandom_range(0, 99);
        rnd  = $urandom;
        obj  = rnd[hta_pkg::OBJ_W-1:0];
        rnd  = $urandom;
        hdl  = rnd[hta_pkg::HDL_W-1:0];
        if (roll < 3) begin
            send_cmd(hta_pkg::OP_NOP, obj, hdl);
        end else if (roll < 5) begin
            send_cmd(hta_pkg::OP_REGISTER, '0, hdl);
        end else if (roll < reg_pct) begin
            if (obj == '0) obj = hta_pkg::OBJ_W'(1);
            if ($urandom_range(0, 99) < dup_pct) begin
                held = sb.slot_obj[live_handle()];
                if (held != '0) obj = held;
            end
            send_cmd(hta_pkg::OP_REGISTER, obj, hdl);
        end else begin
            if ($urandom_range(0, 9) < 7) hdl = live_handle();
            send_cmd($urandom_range(0, 1) ? hta_pkg::OP_LOOKUP : hta_pkg::OP_RELEASE,
                     obj, hdl);
        end
    endtask

    initial begin : result_sink
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int blk;
        int len;
        int reg_pct;
        int dup_pct;
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Corner cases on an empty table, then a short life of a few handles.
        send_cmd(hta_pkg::OP_LOOKUP,   16'h0000, 8'd0);
        send_cmd(hta_pkg::OP_RELEASE,  16'hFFFF, 8'd0);
        send_cmd(hta_pkg::OP_LOOKUP,   16'h0000, 8'd255);
        send_cmd(hta_pkg::OP_RELEASE,  16'h0000, 8'd7);
        send_cmd(hta_pkg::OP_REGISTER, 16'h0000, 8'd255);
        send_cmd(hta_pkg::OP_NOP,      16'hFFFF, 8'd255);
        send_cmd(hta_pkg::OP_REGISTER, 16'hFFFF, 8'd0);
        send_cmd(hta_pkg::OP_REGISTER, 16'h0001, 8'd0);
        send_cmd(hta_pkg::OP_REGISTER, 16'hFFFF, 8'd0);
        send_cmd(hta_pkg::OP_LOOKUP,   16'h0000, 8'd1);
        send_cmd(hta_pkg::OP_LOOKUP,   16'h0000, 8'd2);
        send_cmd(hta_pkg::OP_RELEASE,  16'h0000, 8'd1);
        send_cmd(hta_pkg::OP_LOOKUP,   16'h0000, 8'd1);
        // Next-fit carries on past the slot just freed.
        send_cmd(hta_pkg::OP_REGISTER, 16'h1234, 8'd0);
        send_cmd(hta_pkg::OP_REGISTER, 16'h0001, 8'd0);
        send_cmd(hta_pkg::OP_RELEASE,  16'h0000, 8'd2);
        send_cmd(hta_pkg::OP_RELEASE,  16'h0000, 8'd2);
        send_cmd(hta_pkg::OP_REGISTER, 16'h8000, 8'd0);
        send_cmd(hta_pkg::OP_NOP,      16'h0000, 8'd0);
        send_cmd(hta_pkg::OP_LOOKUP,   16'h0000, 8'd255);

        for (blk = 0; blk < 13; blk++) begin
            if (blk == 3 || blk == 9) begin
                // Enough fresh objects to fill every slot and run into a full table.
                len     = 300;
                reg_pct = 100;
                dup_pct = 5;
            end else begin
                len     = 120;
                reg_pct = $urandom_range(0, 1) ? 55 : 25;
                dup_pct = 20;
            end
            s_tvalid <= 1'b0;
            do @(negedge aclk); while (sb.pending() != 0);
            no_idle = (blk % 4 == 1);
            repeat (len) random_cmd(reg_pct, dup_pct);
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (hta_pkg::SLOTS_DEF + 40) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
